[rtl/core/pidpi_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// pidpi_pkg
// Shared widths, types, register indexes and fixed-point helpers for the
// positional / incremental PID unit.
// ============================================================================
package pidpi_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS     = 16;
    // Three extra bits hold any sum of up to four full-range values exactly.
    localparam int EXT_WIDTH     = DATA_WIDTH + 3;
    localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic        [DATA_WIDTH-2:0] limit_t;
    typedef logic signed [EXT_WIDTH-1:0]  ext_t;
    typedef logic        [CFG_IDX_WIDTH-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MODE  = CFG_IDX_WIDTH'(0);
    localparam cfg_idx_t CFG_KP    = CFG_IDX_WIDTH'(1);
    localparam cfg_idx_t CFG_KI    = CFG_IDX_WIDTH'(2);
    localparam cfg_idx_t CFG_KD    = CFG_IDX_WIDTH'(3);
    localparam cfg_idx_t CFG_LIMIT = CFG_IDX_WIDTH'(4);

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic   mode;
        data_t  kp_gain;
        data_t  ki_gain;
        data_t  kd_gain;
        limit_t output_limit;
    } pid_cfg_t;

    typedef struct packed {
        data_t err_recent;
        data_t err_older;
        data_t integrator;
        data_t held_output;
    } pid_state_t;

    typedef struct packed {
        data_t value;
        logic  hit;
    } clamp_t;

    function automatic ext_t extend(data_t v);
        return EXT_WIDTH'(v);
    endfunction

    // Saturate an exact wide sum to the signed data range.
    function automatic data_t sat_ext(ext_t v);
        if (v > EXT_WIDTH'(DATA_MAX)) begin
            return DATA_MAX;
        end
        if (v < EXT_WIDTH'(DATA_MIN)) begin
            return DATA_MIN;
        end
        return DATA_WIDTH'(v);
    endfunction

    // Symmetric clamp to +/- limit, flagging when the value was changed.
    function automatic clamp_t clamp_lim(data_t v, limit_t lim);
        data_t  pos;
        data_t  neg;
        clamp_t r;
        pos = $signed({1'b0, lim});
        neg = -pos;
        r.value = v;
        r.hit   = 1'b0;
        if (v > pos) begin
            r.value = pos;
            r.hit   = 1'b1;
        end else if (v < neg) begin
            r.value = neg;
            r.hit   = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/core/pid_position_incremental_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// pid_position_incremental_unit
// Positional / incremental PID controller in signed Q16.16 fixed point.
// ============================================================================
// Usage:
//   Slave stream: each beat carries one sample, measured value in the low
//   half of s_tdata and setpoint in the high half. Master stream: each beat
//   carries the clamped drive value on m_tdata and the clamp flag on m_tuser.
//   Exactly one result beat follows every input beat, in order.
//   Configuration channel: cfg_index selects mode (0), kp (1), ki (2),
//   kd (3) or output limit (4). cfg_ready is always high. Any write, also to
//   an unused index, clears the error history, integrator and held output;
//   write only while no sample is in flight.
//   A sample in the sample register moves into the result register, and so onto
//   the master side, once the result stage is free. Throughput: one sample per
//   cycle while the receiver does not hold off; the combinational state update
//   (three gain multipliers, accumulation, clamp) feeds the state registers.
//   Stall: a sample register and a result register part the two sides; when
//   the receiver holds off, the result beat holds its value and one further
//   sample is taken before s_tready drops.
//   Reset (aresetn low, synchronous): all gains, limit and mode go to zero,
//   the controller state is cleared and both stages are emptied.
// ============================================================================
module pid_position_incremental_unit
    import pidpi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // Sample stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [2*DATA_WIDTH-1:0]   s_tdata,   // measured_value, target_value
    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_WIDTH-1:0]     m_tdata,   // drive_value
    output logic                      m_tuser,   // was_clamped
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0]     cfg_data
);

    pid_cfg_t   cfg_reg;
    pid_cfg_t   cfg_next;
    pid_state_t state_reg;
    pid_state_t state_next;
    pid_state_t state_upd;

    logic  in_valid_reg;
    logic  in_valid_next;
    data_t in_meas_reg;
    data_t in_targ_reg;

    logic  out_valid_reg;
    logic  out_valid_next;
    data_t out_drive_reg;
    logic  out_clamp_reg;

    data_t dp_drive;
    logic  dp_clamped;

    logic  s_accept;
    logic  cfg_write;
    logic  advance;

    // The sample stage moves into the result stage whenever the result stage
    // is empty or being emptied this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_drive_reg;
    assign m_tuser   = out_clamp_reg;

    // Register file decode. Only bit 0 of a mode write is kept.
    always_comb begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            CFG_MODE:  cfg_next.mode         = cfg_data[0];
            CFG_KP:    cfg_next.kp_gain      = cfg_data;
            CFG_KI:    cfg_next.ki_gain      = cfg_data;
            CFG_KD:    cfg_next.kd_gain      = cfg_data;
            CFG_LIMIT: cfg_next.output_limit = cfg_data[DATA_WIDTH-2:0];
            default:   cfg_next = cfg_reg;
        endcase
    end

    pidpi_datapath u_datapath (
        .cfg            (cfg_reg),
        .state          (state_reg),
        .measured_value (in_meas_reg),
        .target_value   (in_targ_reg),
        .state_upd      (state_upd),
        .drive_value    (dp_drive),
        .was_clamped    (dp_clamped)
    );

    always_comb begin
        if (cfg_write) begin
            state_next = '0;
        end else if (advance) begin
            state_next = state_upd;
        end else begin
            state_next = state_reg;
        end

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state, configuration and controller history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                cfg_reg <= cfg_next;
            end
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_meas_reg <= s_tdata[DATA_WIDTH-1:0];
            in_targ_reg <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        end
        if (advance) begin
            out_drive_reg <= dp_drive;
            out_clamp_reg <= dp_clamped;
        end
    end

endmodule

[rtl/core/pidpi_qmul.sv]
`timescale 1ns / 1ps
// ============================================================================
// pidpi_qmul
// Fixed-point multiply: full signed product, arithmetic shift right by the
// fraction width (rounds toward minus infinity), saturate to the data range.
// ============================================================================
module pidpi_qmul
    import pidpi_pkg::*;
(
    input  data_t a,
    input  data_t b,
    output data_t q
);

    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [PROD_WIDTH-1:0] shifted;

    always_comb begin
        prod    = PROD_WIDTH'(a) * PROD_WIDTH'(b);
        shifted = prod >>> FRAC_BITS;
        if (shifted > PROD_WIDTH'(DATA_MAX)) begin
            q = DATA_MAX;
        end else if (shifted < PROD_WIDTH'(DATA_MIN)) begin
            q = DATA_MIN;
        end else begin
            q = DATA_WIDTH'(shifted);
        end
    end

endmodule

[rtl/core/pidpi_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// pidpi_datapath
// One-pass PID update: error terms, three shared gain multipliers, integrator
// or held-output accumulation, final clamp and next controller state.
// ============================================================================
module pidpi_datapath
    import pidpi_pkg::*;
(
    input  pid_cfg_t   cfg,
    input  pid_state_t state,
    input  data_t      measured_value,
    input  data_t      target_value,
    output pid_state_t state_upd,
    output data_t      drive_value,
    output logic       was_clamped
);

    data_t  err;
    data_t  diff1;
    data_t  diff2;
    data_t  kp_op;
    data_t  kd_op;
    data_t  kp_term;
    data_t  ki_term;
    data_t  kd_term;
    data_t  integ_sum;
    clamp_t integ_clamp;
    data_t  pos_sum;
    data_t  inc_sum;
    ext_t   delta;
    clamp_t result;

    always_comb begin
        err   = sat_ext(extend(target_value) - extend(measured_value));
        diff1 = sat_ext(extend(err) - extend(state.err_recent));
        diff2 = sat_ext(extend(err) - (extend(state.err_recent) <<< 1)
                        + extend(state.err_older));
        // Positional mode multiplies kp by the error and kd by the first
        // difference; incremental mode uses the first and second differences.
        kp_op = (cfg.mode == MODE_INCREMENTAL) ? diff1 : err;
        kd_op = (cfg.mode == MODE_INCREMENTAL) ? diff2 : diff1;
    end

    pidpi_qmul u_mul_kp (.a(cfg.kp_gain), .b(kp_op), .q(kp_term));
    pidpi_qmul u_mul_ki (.a(cfg.ki_gain), .b(err),   .q(ki_term));
    pidpi_qmul u_mul_kd (.a(cfg.kd_gain), .b(kd_op), .q(kd_term));

    always_comb begin
        integ_sum   = sat_ext(extend(state.integrator) + extend(ki_term));
        integ_clamp = clamp_lim(integ_sum, cfg.output_limit);
        pos_sum     = sat_ext(extend(kp_term) + extend(integ_clamp.value) + extend(kd_term));
        // The incremental delta is kept exact; only its sum with the held
        // output saturates.
        delta       = extend(kp_term) + extend(ki_term) + extend(kd_term);
        inc_sum     = sat_ext(extend(state.held_output) + delta);
        result      = clamp_lim((cfg.mode == MODE_INCREMENTAL) ? inc_sum : pos_sum,
                                cfg.output_limit);

        drive_value = result.value;
        was_clamped = result.hit;

        state_upd.err_recent  = err;
        state_upd.held_output = result.value;
        if (cfg.mode == MODE_INCREMENTAL) begin
            state_upd.err_older  = state.err_recent;
            state_upd.integrator = state.integrator;
        end else begin
            state_upd.err_older  = state.err_older;
            state_upd.integrator = integ_clamp.value;
        end
    end

endmodule

[rtl/core/pidpi_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// pidpi_checker
// Port-level checks of the PID unit's stream and configuration behavior.
// ============================================================================
module pidpi_checker
    import pidpi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [DATA_WIDTH-1:0]     m_tdata,
    input  logic                      m_tuser,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // A result appearing on an empty output comes from a sample that was taken
    // into the sample register and then moved into the result register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result beat without a matching sample");

    // With the output stage empty, the sample side can never be blocked.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("sample side stalled while result stage empty");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind pid_position_incremental_unit pidpi_checker u_pidpi_checker (.*);

[bench/pid_drive_check_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// pid_drive_check_pkg
// Scoreboard for the PID unit: it predicts the drive value and clamp flag of
// every accepted sample and compares them with the result beats.
// ============================================================================
package pid_drive_check_pkg;

    import pidpi_pkg::*;

    // Indexes past the register list still clear the controller history.
    localparam cfg_idx_t CFG_SPARE_FIRST = CFG_IDX_WIDTH'(5);
    localparam cfg_idx_t CFG_SPARE_LAST  = CFG_IDX_WIDTH'(7);

    localparam longint WORD_HI = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint WORD_LO = -WORD_HI - 1;

    typedef struct {
        data_t drive;
        logic  clamped;
    } drive_beat_t;

    class pid_drive_scoreboard;

        logic        mode;
        data_t       kp;
        data_t       ki;
        data_t       kd;
        limit_t      limit;
        data_t       last_err;
        data_t       prev_err;
        data_t       integ;
        data_t       held;
        drive_beat_t drive_q[$];
        int unsigned errors;

        function new();
            mode   = MODE_POSITIONAL;
            kp     = '0;
            ki     = '0;
            kd     = '0;
            limit  = '0;
            errors = 0;
            clear_history();
        endfunction

        function void clear_history();
            last_err = '0;
            prev_err = '0;
            integ    = '0;
            held     = '0;
        endfunction

        function void write_reg(cfg_idx_t idx, data_t value);
            case (idx)
                CFG_MODE:  mode  = value[0];
                CFG_KP:    kp    = value;
                CFG_KI:    ki    = value;
                CFG_KD:    kd    = value;
                CFG_LIMIT: limit = value[DATA_WIDTH-2:0];
                default: ;
            endcase
            clear_history();
        endfunction

        function longint saturate(longint v);
            if (v > WORD_HI) begin
                return WORD_HI;
            end
            if (v < WORD_LO) begin
                return WORD_LO;
            end
            return v;
        endfunction

        // Exact product, floored by the fraction shift, then saturated.
        function longint fx_mul(data_t a, longint b);
            longint p;
            p = longint'(a) * b;
            return saturate(p >>> FRAC_BITS);
        endfunction

        function longint limit_clamp(longint v, output bit hit);
            longint lim;
            lim = longint'(limit);
            hit = 1'b0;
            if (v > lim) begin
                hit = 1'b1;
                return lim;
            end
            if (v < -lim) begin
                hit = 1'b1;
                return -lim;
            end
            return v;
        endfunction

        function void note_sample(data_t meas, data_t targ);
            longint      e;
            longint      d1;
            longint      d2;
            longint      acc;
            longint      res;
            bit          hit;
            bit          integ_hit;
            drive_beat_t beat;
            e = saturate(longint'(targ) - longint'(meas));
            if (mode == MODE_POSITIONAL) begin
                integ = data_t'(limit_clamp(saturate(longint'(integ) + fx_mul(ki, e)),
                                            integ_hit));
                d1  = saturate(e - longint'(last_err));
                acc = saturate(fx_mul(kp, e) + longint'(integ) + fx_mul(kd, d1));
                res = limit_clamp(acc, hit);
            end else begin
                d1  = saturate(e - longint'(last_err));
                d2  = saturate(e - 2 * longint'(last_err) + longint'(prev_err));
                acc = fx_mul(kp, d1) + fx_mul(ki, e) + fx_mul(kd, d2);
                res = limit_clamp(saturate(longint'(held) + acc), hit);
                prev_err = last_err;
            end
            last_err     = data_t'(e);
            held         = data_t'(res);
            beat.drive   = data_t'(res);
            beat.clamped = hit;
            drive_q.push_back(beat);
        endfunction

        function void check_drive(data_t drive, logic clamped);
            drive_beat_t want;
            if (drive_q.size() == 0) begin
                $error("drive_value beat with no sample pending: actual %0d", drive);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (drive !== want.drive) begin
                $error("drive_value mismatch: expected %0d, actual %0d", want.drive, drive);
                errors++;
            end
            if (clamped !== want.clamped) begin
                $error("was_clamped mismatch: expected %0b, actual %0b",
                       want.clamped, clamped);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return drive_q.size();
        endfunction

    endclass

endpackage

[bench/tb_pid_position_incremental_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_pid_position_incremental_unit
// Self-checking bench for the positional / incremental PID unit. A directed
// run covers operand and gain extremes, both modes, the zero limit, the clamp
// and writes to unused indexes; then random control runs under fresh random
// settings. A scoreboard predicts each drive beat, while sender and receiver
// idle at random and the receiver once holds off long enough to back up the
// sample side.
// ============================================================================
module tb_pid_position_incremental_unit;

    import pidpi_pkg::*;
    import pid_drive_check_pkg::*;

    localparam int          RANDOM_BLOCKS   = 25;
    localparam int          ITEMS_PER_BLOCK = 50;
    localparam int          PHASE_B_START   = 9;
    localparam int          PHASE_C_START   = 17;
    localparam int          STALL_BLOCK     = 3;
    localparam int unsigned LONG_STALL      = 300;
    // Settling wait after the last drive beat; it leaves ample margin.
    localparam int          SETTLE_CYCLES   = 8;
    localparam int unsigned LIMIT_CYCLES    = 200000;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [2*DATA_WIDTH-1:0]  s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DATA_WIDTH-1:0]    m_tdata;
    logic                     m_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [DATA_WIDTH-1:0]    cfg_data  = '0;

    // Idle rates in percent (of samples for the sender, of cycles for the receiver), changed only between blocks.
    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 45;

    // Toggling the arm bit asks the receiver for one long hold-off.
    logic        stall_arm  = 1'b0;
    logic        stall_seen = 1'b0;
    int unsigned stall_left = 0;

    int unsigned cycle_count = 0;

    pid_drive_scoreboard drive_sb;

    pid_position_incremental_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off on request. The
    // hold-off is counted here so the sender keeps offering samples meanwhile.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_arm != stall_seen) begin
            stall_seen <= stall_arm;
            stall_left <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: every handshake is seen with the values held at the edge, so
    // the scoreboard follows exactly what the block took in and gave out.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                drive_sb.check_drive(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                drive_sb.note_sample(s_tdata[DATA_WIDTH-1:0], s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
            end
            if (cfg_valid && cfg_ready) begin
                drive_sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    // Watchdog: a run that hangs is reported as a failure.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offers one sample, after an optional random gap, and returns at the
    // edge that accepts it. tvalid stays high for a following sample.
    task automatic send_sample(data_t meas, data_t targ);
        int unsigned gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {targ, meas};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Leaves cfg_valid high so writes can follow back to back; the caller
    // lowers it after the last one.
    task automatic cfg_write(cfg_idx_t idx, logic [DATA_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Stops offering samples and waits until every drive beat is back and
    // the pipeline has had time to empty. The first edge lets the monitor
    // note a sample taken at the edge this task was called on.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (drive_sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all five registers while idle. The mode and limit words may carry
    // set upper bits, which the block must ignore.
    task automatic apply_settings(logic [DATA_WIDTH-1:0] mode_word, data_t kp, data_t ki,
                                  data_t kd, logic [DATA_WIDTH-1:0] limit_word,
                                  bit with_spare);
        drain();
        cfg_write(CFG_MODE, mode_word);
        cfg_write(CFG_KP, kp);
        cfg_write(CFG_KI, ki);
        cfg_write(CFG_KD, kd);
        cfg_write(CFG_LIMIT, limit_word);
        if (with_spare) begin
            cfg_write(cfg_idx_t'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic data_t pick_extreme();
        case ($urandom_range(0, 3))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic data_t near_zero(int unsigned span);
        data_t v;
        v = data_t'($urandom_range(0, span));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Gains are mostly within +/-4.0 so the loop behaves like a controller,
    // with full-range and extreme gains mixed in.
    function automatic data_t rand_gain();
        case ($urandom_range(0, 7))
            0:       return data_t'($urandom);
            1:       return pick_extreme();
            default: return near_zero(32'h0004_0000);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return '0;
            2:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            default: return $urandom_range(0, 32'h0064_0000);
        endcase
    endfunction

    // Mostly a measurement tracking a setpoint with small noise, now and then
    // a setpoint step, and some full-range and extreme noise samples.
    task automatic random_block(int n);
        data_t setpoint;
        data_t meas;
        data_t targ;
        setpoint = near_zero(32'h0020_0000);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: begin
                    meas = data_t'($urandom);
                    targ = data_t'($urandom);
                end
                1: begin
                    meas = pick_extreme();
                    targ = pick_extreme();
                end
                2: begin
                    setpoint = near_zero(32'h0020_0000);
                    targ     = setpoint;
                    meas     = setpoint + near_zero(32'h0008_0000);
                end
                default: begin
                    targ = setpoint;
                    meas = setpoint + near_zero(32'h0002_0000);
                end
            endcase
            send_sample(meas, targ);
        end
    endtask

    initial begin
        drive_sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: zero gains and a zero limit force the output to 0.
        send_sample(DATA_MIN, DATA_MAX);
        send_sample(32'h7FFF_0000, 32'h0001_0000);

        // Positional with modest gains and the widest limit; the operand
        // extremes saturate the error in both directions.
        apply_settings(DATA_WIDTH'(MODE_POSITIONAL), 32'h0001_0000, 32'h0000_8000,
                       32'h0000_4000, 32'h7FFF_FFFF, 1'b0);
        send_sample(DATA_MIN, DATA_MAX);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MAX, DATA_MAX);
        send_sample(DATA_MIN, DATA_MIN);
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0003_0000, 32'h0001_0000);

        // Incremental with extreme gains: products and sums saturate.
        apply_settings(DATA_WIDTH'(MODE_INCREMENTAL), DATA_MIN, DATA_MAX, '1,
                       32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 32'h0001_0000);
        send_sample(32'h0000_0000, DATA_MAX);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(32'h0000_0000, 32'h0000_0000);

        // Incremental against a limit of 10.0, so the held output clamps; only
        // bit 0 of the all-ones mode word counts.
        apply_settings(32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_1999, 32'h0001_0000,
                       32'h000A_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h0003_0000);
        send_sample(32'h0000_0000, 32'h0003_0000);
        send_sample(32'h0000_0000, 32'h0003_0000);
        send_sample(32'h0001_0000, 32'hFFFB_0000);
        send_sample(32'h0000_0000, 32'h0000_0000);

        // Positional with a zero limit and an even mode word with upper bits set.
        apply_settings(32'hFFFF_FFFE, 32'hFFFE_8000, DATA_MIN, DATA_MAX, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h0001_0000);
        send_sample(32'h0005_0000, 32'h0000_0000);
        send_sample(32'h0000_0000, 32'h0000_0000);

        // A write to an unused index keeps the settings but clears history.
        drain();
        cfg_write(CFG_SPARE_LAST, $urandom);
        cfg_valid <= 1'b0;
        send_sample(32'h0000_0000, 32'h0002_0000);
        send_sample(32'h0000_0000, 32'h0002_0000);

        // Random blocks, each under fresh settings, through three idle phases.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            if (blk == PHASE_B_START) begin
                tx_idle_pct = 45;
                rx_idle_pct = 17;
            end
            if (blk == PHASE_C_START) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_settings($urandom, rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                           $urandom_range(0, 3) == 0);
            if (blk == STALL_BLOCK) begin
                stall_arm <= ~stall_arm;
            end
            random_block(ITEMS_PER_BLOCK);
        end

        drain();
        if (drive_sb.errors == 0 && drive_sb.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pidpi_pkg.sv
rtl/core/pidpi_qmul.sv
rtl/core/pidpi_datapath.sv
rtl/core/pid_position_incremental_unit.sv
rtl/core/pidpi_checker.sv
bench/pid_drive_check_pkg.sv
bench/tb_pid_position_incremental_unit.sv
